@@ hdl/rqs_pkg.sv @@
// ----------------------------------------------------------------------------
// rqs_pkg
// Shared types and defaults for the ready queue with shortest-job-first sort.
// ----------------------------------------------------------------------------
package rqs_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int ID_BITS_DEF    = 16;
  localparam int BURST_BITS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_ENQ,
    MODE_DEQ,
    MODE_PEEK,
    MODE_SRCH,
    MODE_SORT
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_FULL,
    STAT_EMPTY
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SRCH,
    ST_SORT_RD,
    ST_SORT_CUR,
    ST_SORT_CMP,
    ST_SORT_PUT,
    ST_RESP
  } state_t;

endpackage

@@ hdl/rqs_if.sv @@
// ----------------------------------------------------------------------------
// rqs_if
// Valid/ready channels of the ready queue: requests in, results out.
// ----------------------------------------------------------------------------
interface rqs_in_if #(
  parameter int ID_BITS    = rqs_pkg::ID_BITS_DEF,
  parameter int BURST_BITS = rqs_pkg::BURST_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            mode;
  logic [ID_BITS-1:0]    entry_id;
  logic [BURST_BITS-1:0] entry_burst;

  modport source (output valid, output mode, output entry_id, output entry_burst,
                  input ready);
  modport sink   (input valid, input mode, input entry_id, input entry_burst,
                  output ready);
endinterface

interface rqs_out_if #(
  parameter int DEPTH      = rqs_pkg::DEPTH_DEF,
  parameter int ID_BITS    = rqs_pkg::ID_BITS_DEF,
  parameter int BURST_BITS = rqs_pkg::BURST_BITS_DEF
);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  valid;
  logic                  ready;
  logic [ID_BITS-1:0]    out_id;
  logic [BURST_BITS-1:0] out_burst;
  logic                  found;
  logic [1:0]            status;
  logic [CW-1:0]         count;

  modport source (output valid, output out_id, output out_burst, output found,
                  output status, output count, input ready);
  modport sink   (input valid, input out_id, input out_burst, input found,
                  input status, input count, output ready);
endinterface

@@ hdl/ready_queue_with_sjf_sort_core.sv @@
// ----------------------------------------------------------------------------
// ready_queue_with_sjf_sort_core
// Ring-buffer ready queue with enqueue, dequeue, peek, search by id and a
// stable insertion sort by burst time, all held in one entry RAM.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    mode, entry_id, entry_burst
//   out_ch   out  valid / ready    out_id, out_burst, found, status, count
//
// One request is in flight at a time. Enqueue, rejected requests and unused modes
// go straight to the response state; dequeue and peek first read the head; a search
// reads one entry per step until a match or the last entry; a sort of n entries
// runs read, capture, compare and put states per entry, shifting greater ones up.
// Reset clears the state, pointers, occupancy and output valid; the RAM is not cleared.
// A stalled result holds the block in its response state until transferred.
// ----------------------------------------------------------------------------
module ready_queue_with_sjf_sort_core #(
  parameter int DEPTH      = rqs_pkg::DEPTH_DEF,
  parameter int ID_BITS    = rqs_pkg::ID_BITS_DEF,
  parameter int BURST_BITS = rqs_pkg::BURST_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rqs_in_if.sink   in_ch,
  rqs_out_if.source out_ch
);
  import rqs_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = ID_BITS + BURST_BITS;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] a);
    return (a == '0) ? LAST_ADDR : a - 1'b1;
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] occ_r, occ_nxt;

  logic                  deq_r, deq_nxt;
  logic [ID_BITS-1:0]    key_r, key_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         j_r, j_nxt;
  logic [AW-1:0]         aj_r, aj_nxt;
  logic [AW-1:0]         am_r, am_nxt;
  logic [EW-1:0]         cur_r, cur_nxt;

  logic [ID_BITS-1:0]    res_id_r, res_id_nxt;
  logic [BURST_BITS-1:0] res_burst_r, res_burst_nxt;
  logic                  res_found_r, res_found_nxt;
  status_t               res_status_r, res_status_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [ID_BITS-1:0]    out_id_r, out_id_nxt;
  logic [BURST_BITS-1:0] out_burst_r, out_burst_nxt;
  logic                  out_found_r, out_found_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [CW-1:0]         out_count_r, out_count_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  logic in_fire;
  logic out_free;
  logic rd_match;
  logic rd_greater;
  logic last_cmp;
  logic last_ins;

  rqs_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign rd_match   = (mem_rdata[EW-1:BURST_BITS] == key_r);
  assign rd_greater = (mem_rdata[BURST_BITS-1:0] > cur_r[BURST_BITS-1:0]);
  assign last_cmp   = ((cnt_r + 1'b1) == occ_r);
  assign last_ins   = ((cnt_r + 1'b1) == occ_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.mode)
            MODE_DEQ, MODE_PEEK: state_nxt = (occ_r == '0) ? ST_RESP : ST_HEAD;
            MODE_SRCH:           state_nxt = (occ_r == '0) ? ST_RESP : ST_SRCH;
            MODE_SORT:           state_nxt = (occ_r <= CW'(1)) ? ST_RESP : ST_SORT_RD;
            default:             state_nxt = ST_RESP;
          endcase
        end
      end
      ST_HEAD:     state_nxt = ST_RESP;
      ST_SRCH:     state_nxt = (rd_match || last_cmp) ? ST_RESP : ST_SRCH;
      ST_SORT_RD:  state_nxt = ST_SORT_CUR;
      ST_SORT_CUR: state_nxt = ST_SORT_CMP;
      ST_SORT_CMP: state_nxt = (rd_greater && (j_r != AW'(1))) ? ST_SORT_CMP : ST_SORT_PUT;
      ST_SORT_PUT: state_nxt = last_ins ? ST_RESP : ST_SORT_RD;
      ST_RESP:     state_nxt = out_free ? ST_IDLE : ST_RESP;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    deq_nxt        = deq_r;
    key_nxt        = key_r;
    ptr_nxt        = ptr_r;
    cnt_nxt        = cnt_r;
    j_nxt          = j_r;
    aj_nxt         = aj_r;
    am_nxt         = am_r;
    cur_nxt        = cur_r;
    res_id_nxt     = res_id_r;
    res_burst_nxt  = res_burst_r;
    res_found_nxt  = res_found_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_id_nxt     = out_id_r;
    out_burst_nxt  = out_burst_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = aj_r;
    mem_wdata      = cur_r;
    mem_raddr      = ptr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_id_nxt     = '0;
          res_burst_nxt  = '0;
          res_found_nxt  = 1'b0;
          res_status_nxt = STAT_OK;
          deq_nxt        = (in_ch.mode == MODE_DEQ);
          key_nxt        = in_ch.entry_id;
          mem_raddr      = head_r;
          ptr_nxt        = ring_next(head_r);
          cnt_nxt        = '0;
          unique case (in_ch.mode)
            MODE_ENQ: begin
              if (occ_r == FULL_CNT) begin
                res_status_nxt = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_r;
                mem_wdata = {in_ch.entry_id, in_ch.entry_burst};
                tail_nxt  = ring_next(tail_r);
                occ_nxt   = occ_r + 1'b1;
              end
            end
            MODE_DEQ, MODE_PEEK: begin
              if (occ_r == '0) begin
                res_status_nxt = STAT_EMPTY;
              end
            end
            MODE_SORT: cnt_nxt = CW'(1);
            default: ;
          endcase
        end
      end
      ST_HEAD: begin
        res_id_nxt    = mem_rdata[EW-1:BURST_BITS];
        res_burst_nxt = mem_rdata[BURST_BITS-1:0];
        if (deq_r) begin
          head_nxt = ring_next(head_r);
          occ_nxt  = occ_r - 1'b1;
        end
      end
      ST_SRCH: begin
        res_found_nxt = rd_match;
        ptr_nxt       = ring_next(ptr_r);
        cnt_nxt       = cnt_r + 1'b1;
      end
      ST_SORT_RD: ;
      ST_SORT_CUR: begin
        cur_nxt   = mem_rdata;
        j_nxt     = cnt_r[AW-1:0];
        aj_nxt    = ptr_r;
        am_nxt    = ring_prev(ptr_r);
        mem_raddr = ring_prev(ptr_r);
      end
      ST_SORT_CMP: begin
        mem_raddr = ring_prev(am_r);
        if (rd_greater) begin
          mem_we    = 1'b1;
          mem_waddr = aj_r;
          mem_wdata = mem_rdata;
          aj_nxt    = am_r;
          am_nxt    = ring_prev(am_r);
          j_nxt     = j_r - 1'b1;
        end
      end
      ST_SORT_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = aj_r;
        mem_wdata = cur_r;
        cnt_nxt   = cnt_r + 1'b1;
        ptr_nxt   = ring_next(ptr_r);
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_id_nxt     = res_id_r;
          out_burst_nxt  = res_burst_r;
          out_found_nxt  = res_found_r;
          out_status_nxt = res_status_r;
          out_count_nxt  = occ_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    deq_r        <= deq_nxt;
    key_r        <= key_nxt;
    ptr_r        <= ptr_nxt;
    cnt_r        <= cnt_nxt;
    j_r          <= j_nxt;
    aj_r         <= aj_nxt;
    am_r         <= am_nxt;
    cur_r        <= cur_nxt;
    res_id_r     <= res_id_nxt;
    res_burst_r  <= res_burst_nxt;
    res_found_r  <= res_found_nxt;
    res_status_r <= res_status_nxt;
    out_id_r     <= out_id_nxt;
    out_burst_r  <= out_burst_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.out_burst = out_burst_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.count     = out_count_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= FULL_CNT)
    else $error("Occupancy exceeds the queue depth.");

  a_enq_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_ch.mode == MODE_ENQ) && (occ_r != FULL_CNT)
      |=> occ_r == $past(occ_r) + 1'b1)
    else $error("Accepted enqueue did not raise the occupancy by one.");

  a_occ_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire && (state_r != ST_HEAD) |=> $stable(occ_r))
    else $error("Occupancy changed outside an enqueue or dequeue.");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) && out_valid_r && !out_ch.ready |=> state_r == ST_RESP)
    else $error("Response state left while the previous result was stalled.");
`endif

endmodule

@@ hdl/rqs_ram.sv @@
// ----------------------------------------------------------------------------
// rqs_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
